// ===== hw/rtl/lcss_pkg.sv =====
// Shared types, constants and character tables of the line command slot store.
package lcss_pkg;

	// Default sizes
	localparam int SLOT_COUNT_DEF = 8;
	localparam int SLOT_BYTES_DEF = 32;
	localparam int LINE_BYTES_DEF = 40;
	localparam int MEM_BYTES      = 256;
	localparam int MEM_AW         = 8;

	// Characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_BRACE = 8'h7D;
	localparam logic [7:0] CH_ERASE = 8'hFF;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QM    = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_R     = 8'h72;

	// Line read address selection
	typedef enum logic [1:0] {
		LRD_HEAD0,
		LRD_HEAD1,
		LRD_HEAD2,
		LRD_STORE
	} lrd_sel_t;

	// Fixed reply texts
	typedef enum logic [1:0] {
		REPLY_STO,
		REPLY_CLR,
		REPLY_ERR,
		REPLY_CRLF
	} reply_t;

	// Source of the output word
	typedef enum logic {
		OUT_SLOT,
		OUT_TEXT
	} out_src_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_HEAD0,
		S_HEAD1,
		S_HEAD2,
		S_HEAD3,
		S_DECODE,
		S_ST_RD,
		S_ST_WR,
		S_LS_RD,
		S_LS_CHK,
		S_TXT
	} lcss_state_t;

	// Controller to datapath
	typedef struct packed {
		logic     rx_open;
		logic     lrd_en;
		lrd_sel_t lrd_sel;
		logic     cap0;
		logic     cap1;
		logic     cap2;
		logic     dec_load;
		logic     st_wr;
		logic     srd_en;
		logic     out_load;
		out_src_t out_src;
		logic     clr;
		logic     txt_start;
		reply_t   txt_kind;
	} lcss_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic run;
		logic out_free;
		logic is_store;
		logic is_list;
		logic is_clear;
		logic idx_last;
		logic srd_ok;
		logic txt_last;
	} lcss_stat_t;

	// Slot number of a digit or lowercase letter character, zero for anything else
	function automatic logic [5:0] slot_of(input logic [7:0] ch);
		logic [7:0] v;
		v = 8'd0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			v = ch - CH_ZERO;
		end else if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
			v = ch - CH_LC_A + 8'd10;
		end
		return v[5:0];
	endfunction

	// Length of a reply text
	function automatic logic [2:0] reply_len(input reply_t kind);
		logic [2:0] n;
		case (kind)
			REPLY_CRLF: n = 3'd2;
			default:    n = 3'd5;
		endcase
		return n;
	endfunction

	// Character of a reply text at a position
	function automatic logic [7:0] reply_char(input reply_t kind, input logic [2:0] idx);
		logic [7:0] c;
		logic [2:0] pos;
		// Line ending sits in the last two places of every text
		pos = (kind == REPLY_CRLF) ? idx + 3'd3 : idx;
		case (pos)
			3'd0: begin
				case (kind)
					REPLY_STO: c = CH_S;
					REPLY_CLR: c = CH_C;
					default:   c = CH_E;
				endcase
			end
			3'd1: begin
				case (kind)
					REPLY_STO: c = CH_T;
					REPLY_CLR: c = CH_L;
					default:   c = CH_R;
				endcase
			end
			3'd2: begin
				case (kind)
					REPLY_STO: c = CH_O;
					default:   c = CH_R;
				endcase
			end
			3'd3:    c = CH_CR;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/lcss_ctrl.sv =====
// Command sequencer of the line command slot store.
module lcss_ctrl
	import lcss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lcss_stat_t stat,
	output lcss_cmd_t  cmd
);

	lcss_state_t state_q;
	lcss_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.rx_open = 1'b1;
				if (stat.run) begin
					state_d = S_HEAD0;
				end
			end
			// Fetch the first three line characters
			S_HEAD0: begin
				cmd.lrd_en  = 1'b1;
				cmd.lrd_sel = LRD_HEAD0;
				state_d     = S_HEAD1;
			end
			S_HEAD1: begin
				cmd.lrd_en  = 1'b1;
				cmd.lrd_sel = LRD_HEAD1;
				cmd.cap0    = 1'b1;
				state_d     = S_HEAD2;
			end
			S_HEAD2: begin
				cmd.lrd_en  = 1'b1;
				cmd.lrd_sel = LRD_HEAD2;
				cmd.cap1    = 1'b1;
				state_d     = S_HEAD3;
			end
			S_HEAD3: begin
				cmd.cap2 = 1'b1;
				state_d  = S_DECODE;
			end
			// Pick the command
			S_DECODE: begin
				cmd.dec_load = 1'b1;
				if (stat.is_store) begin
					state_d = S_ST_RD;
				end else if (stat.is_list) begin
					state_d = S_LS_RD;
				end else if (stat.is_clear) begin
					cmd.clr       = 1'b1;
					cmd.txt_start = 1'b1;
					cmd.txt_kind  = REPLY_CLR;
					state_d       = S_TXT;
				end else begin
					cmd.txt_start = 1'b1;
					cmd.txt_kind  = REPLY_ERR;
					state_d       = S_TXT;
				end
			end
			// Copy line bytes into the slot
			S_ST_RD: begin
				cmd.lrd_en  = 1'b1;
				cmd.lrd_sel = LRD_STORE;
				state_d     = S_ST_WR;
			end
			S_ST_WR: begin
				cmd.st_wr = 1'b1;
				if (stat.idx_last) begin
					cmd.txt_start = 1'b1;
					cmd.txt_kind  = REPLY_STO;
					state_d       = S_TXT;
				end else begin
					state_d = S_ST_RD;
				end
			end
			// Echo slot bytes until one outside space to closing brace, or the slot end
			S_LS_RD: begin
				cmd.srd_en = 1'b1;
				state_d    = S_LS_CHK;
			end
			S_LS_CHK: begin
				if (!stat.srd_ok) begin
					cmd.txt_start = 1'b1;
					cmd.txt_kind  = REPLY_CRLF;
					state_d       = S_TXT;
				end else if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = OUT_SLOT;
					if (stat.idx_last) begin
						cmd.txt_start = 1'b1;
						cmd.txt_kind  = REPLY_CRLF;
						state_d       = S_TXT;
					end else begin
						state_d = S_LS_RD;
					end
				end
			end
			// Send the fixed reply text
			S_TXT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = OUT_TEXT;
					if (stat.txt_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/lcss_dp.sv =====
// Datapath of the line command slot store: line buffer, slot memory, output register.
module lcss_dp
	import lcss_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int SLOT_BYTES = SLOT_BYTES_DEF,
	parameter int LINE_BYTES = LINE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lcss_cmd_t  cmd,
	output lcss_stat_t stat,
	input  logic       rx_valid,
	input  logic [7:0] rx_byte,
	output logic       tx_valid,
	input  logic       tx_ready,
	output logic [7:0] tx_byte,
	output logic       reply_last
);

	localparam int LEN_W  = $clog2(LINE_BYTES + 1);
	localparam int LIDX_W = $clog2(LINE_BYTES);
	localparam int SRC_W  = $clog2(SLOT_BYTES + 3);
	localparam int CMP_W  = (LEN_W > SRC_W) ? LEN_W : SRC_W;
	localparam int IDX_W  = $clog2(SLOT_BYTES + 1);
	localparam logic [LEN_W-1:0]  LINE_FULL = LEN_W'(LINE_BYTES);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(SLOT_BYTES - 1);
	localparam logic [MEM_AW-1:0] SB_MOD    = MEM_AW'(SLOT_BYTES % MEM_BYTES);
	localparam logic [6:0]        SLOT_LIM  = 7'(SLOT_COUNT);

	// Line buffer
	logic [7:0]       line_mem [LINE_BYTES];
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] eff_len;
	logic             rx_acc;
	logic             rx_end;
	logic             rx_print;
	logic             rx_del;
	logic             line_wr;
	logic [CMP_W-1:0] lrd_addr;
	logic             lrd_in;
	logic [7:0]       lrd_q;
	logic             lrd_ok_q;
	logic [7:0]       lrd_data;

	// Command head
	logic [7:0] c0_q;
	logic [7:0] c1_q;
	logic [7:0] c2_q;
	logic [5:0] slot_num;
	logic       slot_ok;

	// Slot memory, erased bytes tracked by valid bits
	logic [7:0]           slot_mem [MEM_BYTES];
	logic [MEM_BYTES-1:0] vld_q;
	logic [MEM_AW-1:0]    addr_q;
	logic [IDX_W-1:0]     idx_q;
	logic [13:0]          base_prod;
	logic [7:0]           srd_q;
	logic                 srd_vld_q;
	logic [7:0]           srd_data;
	logic                 advance;

	// Reply text and output word
	reply_t     kind_q;
	logic [2:0] txt_idx_q;
	logic       txt_last;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_free;

	// Decode the received word
	assign rx_acc   = rx_valid && cmd.rx_open;
	assign eff_len  = (len_q >= LINE_FULL) ? '0 : len_q;
	assign rx_end   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign rx_del   = (rx_byte == CH_DEL);
	assign rx_print = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);
	assign line_wr  = rx_acc && rx_print;

	// Edit the line length; a finished command empties the line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.txt_start) begin
			len_q <= '0;
		end else if (rx_acc) begin
			if (rx_del) begin
				len_q <= (eff_len == '0) ? '0 : eff_len - LEN_W'(1);
			end else if (rx_print) begin
				len_q <= eff_len + LEN_W'(1);
			end else begin
				len_q <= eff_len;
			end
		end
	end

	// Line read address; bytes past the typed length read as zero
	always_comb begin
		case (cmd.lrd_sel)
			LRD_HEAD0: lrd_addr = CMP_W'(0);
			LRD_HEAD1: lrd_addr = CMP_W'(1);
			LRD_HEAD2: lrd_addr = CMP_W'(2);
			default:   lrd_addr = CMP_W'(idx_q) + CMP_W'(3);
		endcase
	end
	assign lrd_in = lrd_addr < CMP_W'(len_q);

	// Line buffer write and registered read
	always_ff @(posedge clk) begin
		if (line_wr) begin
			line_mem[eff_len[LIDX_W-1:0]] <= rx_byte;
		end
		if (cmd.lrd_en) begin
			lrd_q <= line_mem[lrd_addr[LIDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lrd_ok_q <= 1'b0;
		end else if (cmd.lrd_en) begin
			lrd_ok_q <= lrd_in;
		end
	end
	assign lrd_data = lrd_ok_q ? lrd_q : 8'h00;

	// Capture the command head
	always_ff @(posedge clk) begin
		if (cmd.cap0) begin
			c0_q <= lrd_data;
		end
		if (cmd.cap1) begin
			c1_q <= lrd_data;
		end
		if (cmd.cap2) begin
			c2_q <= lrd_data;
		end
	end

	assign slot_num  = slot_of(c1_q);
	assign slot_ok   = (slot_num != 6'd0) && ({1'b0, slot_num} < SLOT_LIM);
	assign base_prod = {8'd0, slot_num} * {6'd0, SB_MOD};

	// Slot address and byte counter
	assign advance = cmd.st_wr || (cmd.out_load && (cmd.out_src == OUT_SLOT));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			idx_q  <= '0;
		end else if (cmd.dec_load) begin
			addr_q <= base_prod[MEM_AW-1:0];
			idx_q  <= '0;
		end else if (advance) begin
			addr_q <= addr_q + MEM_AW'(1);
			idx_q  <= idx_q + IDX_W'(1);
		end
	end

	// Slot memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.st_wr) begin
			slot_mem[addr_q] <= lrd_data;
		end
		if (cmd.srd_en) begin
			srd_q <= slot_mem[addr_q];
		end
	end

	// Valid bits: erase all at once, mark on store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			srd_vld_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				vld_q <= '0;
			end else if (cmd.st_wr) begin
				vld_q[addr_q] <= 1'b1;
			end
			if (cmd.srd_en) begin
				srd_vld_q <= vld_q[addr_q];
			end
		end
	end
	assign srd_data = srd_vld_q ? srd_q : CH_ERASE;

	// Reply text position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= REPLY_ERR;
			txt_idx_q <= '0;
		end else if (cmd.txt_start) begin
			kind_q    <= cmd.txt_kind;
			txt_idx_q <= '0;
		end else if (cmd.out_load && (cmd.out_src == OUT_TEXT)) begin
			txt_idx_q <= txt_idx_q + 3'd1;
		end
	end
	assign txt_last = (txt_idx_q == reply_len(kind_q) - 3'd1);

	// Output register: load a word, drop it once taken
	assign out_free = !out_valid_q || tx_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (tx_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_src == OUT_TEXT) begin
				out_byte_q <= reply_char(kind_q, txt_idx_q);
				out_last_q <= txt_last;
			end else begin
				out_byte_q <= srd_data;
				out_last_q <= 1'b0;
			end
		end
	end

	assign tx_valid   = out_valid_q;
	assign tx_byte    = out_byte_q;
	assign reply_last = out_last_q;

	// Status to the sequencer
	always_comb begin
		stat          = '0;
		stat.run      = rx_acc && rx_end && (eff_len != '0);
		stat.out_free = out_free;
		stat.is_store = (c0_q == CH_P) && slot_ok && (c2_q == CH_EQ);
		stat.is_list  = (c0_q == CH_L) && slot_ok && (c2_q == CH_QM);
		stat.is_clear = (c0_q == CH_C) && (c1_q == CH_BANG);
		stat.idx_last = (idx_q == IDX_LAST);
		stat.srd_ok   = (srd_data >= CH_SPACE) && (srd_data <= CH_BRACE);
		stat.txt_last = txt_last;
	end

endmodule

// ===== hw/rtl/line_command_slot_store.sv =====
// Line command slot store: edits a received command line and runs it on the slot memory.
// An edit word updates the line; an ending word runs a command that decodes the line head,
// stores by a line read and slot write per byte, lists by slot read and check per byte.
// Throughput: one input word per cycle while editing; no input is taken while a command
// runs, its length set by the slot copy loop and the single output register.
// Reset: asynchronous; the line empties and every slot byte reads as erased (0xFF) at once.
module line_command_slot_store
	import lcss_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int SLOT_BYTES = SLOT_BYTES_DEF,
	parameter int LINE_BYTES = LINE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] tx_byte
	output logic       m_tlast   // reply_last
);

	lcss_cmd_t  cmd;
	lcss_stat_t stat;

	assign s_tready = cmd.rx_open;

	// Sequencer
	lcss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Storage and output word
	lcss_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_BYTES (SLOT_BYTES),
		.LINE_BYTES (LINE_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.rx_valid   (s_tvalid),
		.rx_byte    (s_tdata),
		.tx_valid   (m_tvalid),
		.tx_ready   (m_tready),
		.tx_byte    (m_tdata),
		.reply_last (m_tlast)
	);

endmodule
